@@ hdl/hrhp_pkg.sv @@
// shared types and constants for the http request header parser
package hrhp_pkg;

    // parse phases, one-hot
    typedef enum logic [4:0] {
        PH_REQLINE = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_SKIPSP  = 5'b00100,
        PH_VALUE   = 5'b01000,
        PH_BODY    = 5'b10000
    } t_phase;

    // number scan phases
    typedef enum logic [1:0] {
        NUM_BLANK = 2'd0,
        NUM_SIGN  = 2'd1,
        NUM_DIGIT = 2'd2,
        NUM_DONE  = 2'd3
    } t_num;

    localparam logic [2:0] NM_KEY  = 3'b001;
    localparam logic [2:0] NM_AUTH = 3'b010;
    localparam logic [2:0] NM_CLEN = 3'b100;
    localparam logic [2:0] NM_ALL  = 3'b111;

    localparam logic [3:0] LEN_KEY    = 4'd9;
    localparam logic [3:0] LEN_AUTH   = 4'd13;
    localparam logic [3:0] LEN_CLEN   = 4'd14;
    localparam logic [2:0] LEN_BEARER = 3'd7;

    localparam logic [30:0] CL_SAT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        parse_ok;
        logic [15:0] method_len;
        logic [15:0] path_offset;
        logic [15:0] path_len;
        logic [15:0] key_start;
        logic [15:0] key_len;
        logic [15:0] token_start;
        logic [15:0] token_len;
        logic [30:0] content_len;
        logic [16:0] body_start;
        logic [16:0] body_len;
    } t_out;

    // lower-case header name characters
    function automatic logic [7:0] key_chr(input logic [3:0] i);
        case (i)
            4'd0: key_chr = "x";  4'd1: key_chr = "-";  4'd2: key_chr = "a";
            4'd3: key_chr = "p";  4'd4: key_chr = "i";  4'd5: key_chr = "-";
            4'd6: key_chr = "k";  4'd7: key_chr = "e";  4'd8: key_chr = "y";
            default: key_chr = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] auth_chr(input logic [3:0] i);
        case (i)
            4'd0: auth_chr = "a";  4'd1: auth_chr = "u";  4'd2: auth_chr = "t";
            4'd3: auth_chr = "h";  4'd4: auth_chr = "o";  4'd5: auth_chr = "r";
            4'd6: auth_chr = "i";  4'd7: auth_chr = "z";  4'd8: auth_chr = "a";
            4'd9: auth_chr = "t";  4'd10: auth_chr = "i"; 4'd11: auth_chr = "o";
            4'd12: auth_chr = "n";
            default: auth_chr = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clen_chr(input logic [3:0] i);
        case (i)
            4'd0: clen_chr = "c";  4'd1: clen_chr = "o";  4'd2: clen_chr = "n";
            4'd3: clen_chr = "t";  4'd4: clen_chr = "e";  4'd5: clen_chr = "n";
            4'd6: clen_chr = "t";  4'd7: clen_chr = "-";  4'd8: clen_chr = "l";
            4'd9: clen_chr = "e";  4'd10: clen_chr = "n"; 4'd11: clen_chr = "g";
            4'd12: clen_chr = "t"; 4'd13: clen_chr = "h";
            default: clen_chr = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] bearer_chr(input logic [2:0] i);
        case (i)
            3'd0: bearer_chr = "B"; 3'd1: bearer_chr = "e"; 3'd2: bearer_chr = "a";
            3'd3: bearer_chr = "r"; 3'd4: bearer_chr = "e"; 3'd5: bearer_chr = "r";
            3'd6: bearer_chr = " ";
            default: bearer_chr = 8'h00;
        endcase
    endfunction

endpackage

@@ hdl/hrhp_if.sv @@
// valid/ready channel interfaces for request bytes and results
interface hrhp_in_if;
    logic             valid;
    logic             ready;
    hrhp_pkg::t_in    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hrhp_out_if;
    logic             valid;
    logic             ready;
    hrhp_pkg::t_out   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/http_request_header_parser_unit.sv @@
// top level of the http request header parser
// an accepted last byte's result is registered in the output register, or in the
// one-entry skid buffer behind it while it is stalled; throughput: one byte per
// cycle while the skid is empty, so a byte is taken while a result waits
// reset: synchronous active low, clears parse state and both result valid flags
// after each request's last byte the parse state returns to its reset values
module http_request_header_parser_unit #(
    parameter int MAX_REQ_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrhp_in_if.sink       i_req,
    hrhp_out_if.source    o_res
);
    localparam int PW = $clog2(MAX_REQ_BYTES + 1);

    logic             acc;
    logic [7:0]       b;
    logic             last;

    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_sp1, n_sp1, r_sp2, n_sp2;
    logic             r_f1, n_f1, r_f2, n_f2;
    hrhp_pkg::t_phase r_ph, n_ph;
    logic             r_cr, n_cr;
    logic [PW-1:0]    r_ls, n_ls;
    logic [2:0]       r_nm, n_nm;
    logic [3:0]       r_nl, n_nl;
    logic [PW-1:0]    r_vs, n_vs;
    logic [2:0]       r_bm, n_bm;
    logic [30:0]      r_acc, n_acc;
    logic             r_neg, n_neg;
    hrhp_pkg::t_num   r_np, n_np;
    logic [PW-1:0]    r_ks, n_ks, r_kl, n_kl, r_ts, n_ts, r_tl, n_tl;
    logic [30:0]      r_cl, n_cl;

    // output register plus skid
    logic             r_ov, r_sv;
    hrhp_pkg::t_out   r_od, r_sd, res;

    assign i_req.ready = !r_sv;
    assign acc  = i_req.valid && i_req.ready;
    assign b    = i_req.payload.data_byte;
    assign last = i_req.payload.last_byte;
    assign o_res.valid   = r_ov;
    assign o_res.payload = r_od;

    // per-byte parse step
    always_comb begin
        logic [PW-1:0]    p, e;
        logic [7:0]       c, lc;
        logic             do_line, is_dig, blank;
        logic [2:0]       m;
        logic [PW-1:0]    len;
        logic [34:0]      v;
        logic             drop;
        hrhp_pkg::t_phase s_ph;
        logic [2:0]       s_nm;
        logic [3:0]       s_nl;
        hrhp_pkg::t_num   s_np;
        n_pos = r_pos; n_sp1 = r_sp1; n_sp2 = r_sp2; n_f1 = r_f1; n_f2 = r_f2;
        n_ph = r_ph; n_cr = r_cr; n_ls = r_ls; n_nm = r_nm; n_nl = r_nl;
        n_vs = r_vs; n_bm = r_bm; n_acc = r_acc; n_neg = r_neg; n_np = r_np;
        n_ks = r_ks; n_kl = r_kl; n_ts = r_ts; n_tl = r_tl; n_cl = r_cl;
        p = r_pos; e = r_pos - 1'b1; c = b; do_line = 1'b0;
        lc = 8'h00; is_dig = 1'b0; blank = 1'b0; m = 3'b000; len = '0; v = '0;
        drop = 1'b0;
        s_ph = r_ph; s_nm = r_nm; s_nl = r_nl; s_np = r_np;
        if (r_pos < PW'(MAX_REQ_BYTES)) begin
            n_pos = r_pos + 1'b1;
            if (b == " ") begin
                if (!r_f1) begin
                    n_sp1 = p; n_f1 = 1'b1;
                end else if (!r_f2) begin
                    n_sp2 = p; n_f2 = 1'b1;
                end
            end
            if (r_ph == hrhp_pkg::PH_REQLINE) begin
                if (r_cr && b == 8'h0A) begin
                    n_ph = hrhp_pkg::PH_NAME; n_ls = p + 1'b1;
                    n_nm = hrhp_pkg::NM_ALL; n_nl = '0;
                end
                n_cr = (b == 8'h0D);
            end else if (r_ph != hrhp_pkg::PH_BODY) begin
                if (r_cr && b == 8'h0A) begin
                    // end of line
                    n_cr = 1'b0;
                    len = e - r_vs;
                    if (r_ph == hrhp_pkg::PH_NAME && e == r_ls) begin
                        n_ph = hrhp_pkg::PH_BODY;
                    end else begin
                        if (r_ph != hrhp_pkg::PH_NAME) begin
                            if (r_nm == hrhp_pkg::NM_KEY) begin
                                n_ks = r_vs; n_kl = len;
                            end else if (r_nm == hrhp_pkg::NM_AUTH) begin
                                drop = (len > PW'(hrhp_pkg::LEN_BEARER)) &&
                                       (r_bm == hrhp_pkg::LEN_BEARER);
                                n_ts = drop ? r_vs + PW'(hrhp_pkg::LEN_BEARER) : r_vs;
                                n_tl = drop ? len - PW'(hrhp_pkg::LEN_BEARER) : len;
                            end else if (r_nm == hrhp_pkg::NM_CLEN) begin
                                n_cl = r_neg ? '0 : r_acc;
                            end
                        end
                        n_ph = hrhp_pkg::PH_NAME;
                        n_nm = hrhp_pkg::NM_ALL; n_nl = '0;
                    end
                    n_ls = e + 2'd2;
                end else begin
                    // a held CR not followed by LF is a line byte ahead of this one
                    n_cr = (b == 8'h0D);
                    if (r_cr) begin
                        if (r_ph == hrhp_pkg::PH_NAME) begin
                            s_nm = '0;
                            if (r_nl < 4'd15) s_nl = r_nl + 1'b1;
                        end else begin
                            // CR is a blank value byte: it ends a sign or a digit run
                            s_ph = hrhp_pkg::PH_VALUE;
                            if (r_np == hrhp_pkg::NUM_SIGN || r_np == hrhp_pkg::NUM_DIGIT)
                                s_np = hrhp_pkg::NUM_DONE;
                        end
                    end
                    n_ph = s_ph; n_nm = s_nm; n_nl = s_nl; n_np = s_np;
                    do_line = (b != 8'h0D);
                end
                if (do_line) begin
                    if (s_ph == hrhp_pkg::PH_NAME) begin
                        if (c == ":") begin
                            if (s_nm[0] && s_nl == hrhp_pkg::LEN_KEY)  m = hrhp_pkg::NM_KEY;
                            if (s_nm[1] && s_nl == hrhp_pkg::LEN_AUTH) m = hrhp_pkg::NM_AUTH;
                            if (s_nm[2] && s_nl == hrhp_pkg::LEN_CLEN) m = hrhp_pkg::NM_CLEN;
                            n_nm = m; n_ph = hrhp_pkg::PH_SKIPSP; n_vs = p + 1'b1;
                            n_bm = '0; n_acc = '0; n_neg = 1'b0;
                            n_np = hrhp_pkg::NUM_BLANK;
                        end else begin
                            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                            if (!(s_nl < hrhp_pkg::LEN_KEY && lc == hrhp_pkg::key_chr(s_nl)))
                                n_nm[0] = 1'b0;
                            if (!(s_nl < hrhp_pkg::LEN_AUTH && lc == hrhp_pkg::auth_chr(s_nl)))
                                n_nm[1] = 1'b0;
                            if (!(s_nl < hrhp_pkg::LEN_CLEN && lc == hrhp_pkg::clen_chr(s_nl)))
                                n_nm[2] = 1'b0;
                            if (s_nl < 4'd15) n_nl = s_nl + 1'b1;
                        end
                    end else if (s_ph == hrhp_pkg::PH_SKIPSP && c == " ") begin
                        n_vs = p + 1'b1;
                    end else begin
                        // value byte
                        n_ph = hrhp_pkg::PH_VALUE;
                        is_dig = (c >= "0" && c <= "9");
                        blank = (c == " " || (c >= 8'h09 && c <= 8'h0D));
                        if (r_bm < hrhp_pkg::LEN_BEARER && (p - r_vs) == PW'(r_bm) &&
                            c == hrhp_pkg::bearer_chr(r_bm))
                            n_bm = r_bm + 1'b1;
                        v = {4'd0, r_acc} * 35'd10 + {31'd0, c[3:0]};
                        case (s_np)
                            hrhp_pkg::NUM_BLANK: begin
                                if (!blank) begin
                                    if (c == "+") n_np = hrhp_pkg::NUM_SIGN;
                                    else if (c == "-") begin
                                        n_neg = 1'b1; n_np = hrhp_pkg::NUM_SIGN;
                                    end else if (is_dig) begin
                                        n_acc = {27'd0, c[3:0]}; n_np = hrhp_pkg::NUM_DIGIT;
                                    end else n_np = hrhp_pkg::NUM_DONE;
                                end
                            end
                            hrhp_pkg::NUM_SIGN: begin
                                if (is_dig) begin
                                    n_acc = {27'd0, c[3:0]}; n_np = hrhp_pkg::NUM_DIGIT;
                                end else n_np = hrhp_pkg::NUM_DONE;
                            end
                            hrhp_pkg::NUM_DIGIT: begin
                                if (is_dig)
                                    n_acc = (v > {4'd0, hrhp_pkg::CL_SAT}) ?
                                            hrhp_pkg::CL_SAT : v[30:0];
                                else n_np = hrhp_pkg::NUM_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    // result from the post-byte state
    always_comb begin
        logic [PW-1:0] rem;
        logic [PW-1:0] bl;
        res = '0; rem = n_pos - n_ls; bl = '0;
        if (n_f1 && n_f2 && n_ph != hrhp_pkg::PH_REQLINE) begin
            if (n_cl != '0 && n_ls < n_pos)
                bl = ({{(32-PW){1'b0}}, rem} > {1'b0, n_cl}) ? PW'(n_cl) : rem;
            res.parse_ok       = 1'b1;
            res.method_len     = 16'(n_sp1);
            res.path_offset    = 16'(n_sp1 + 1'b1);
            res.path_len       = 16'(n_sp2 - n_sp1 - 1'b1);
            res.key_start      = 16'(n_ks);
            res.key_len        = 16'(n_kl);
            res.token_start    = 16'(n_ts);
            res.token_len      = 16'(n_tl);
            res.content_len    = n_cl;
            res.body_start     = 17'(n_ls);
            res.body_len       = 17'(bl);
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && last)) begin
            r_pos <= '0; r_sp1 <= '0; r_sp2 <= '0; r_f1 <= 1'b0; r_f2 <= 1'b0;
            r_ph <= hrhp_pkg::PH_REQLINE; r_cr <= 1'b0; r_ls <= '0;
            r_nm <= hrhp_pkg::NM_ALL; r_nl <= '0; r_vs <= '0; r_bm <= '0;
            r_acc <= '0; r_neg <= 1'b0; r_np <= hrhp_pkg::NUM_BLANK;
            r_ks <= '0; r_kl <= '0; r_ts <= '0; r_tl <= '0; r_cl <= '0;
        end else if (acc) begin
            r_pos <= n_pos; r_sp1 <= n_sp1; r_sp2 <= n_sp2; r_f1 <= n_f1; r_f2 <= n_f2;
            r_ph <= n_ph; r_cr <= n_cr; r_ls <= n_ls; r_nm <= n_nm; r_nl <= n_nl;
            r_vs <= n_vs; r_bm <= n_bm; r_acc <= n_acc; r_neg <= n_neg; r_np <= n_np;
            r_ks <= n_ks; r_kl <= n_kl; r_ts <= n_ts; r_tl <= n_tl; r_cl <= n_cl;
        end
    end

    // result register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (!r_ov || o_res.ready) begin
                r_ov <= r_sv || (acc && last);
                r_od <= r_sv ? r_sd : res;
                r_sv <= 1'b0;
            end else if (acc && last) begin
                r_sv <= 1'b1; r_sd <= res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid holds a result while output empty");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> (r_ov && $stable(r_od)))
        else $error("stalled result changed");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last) |=> (r_pos == '0 && r_ph == hrhp_pkg::PH_REQLINE))
        else $error("state not cleared after last byte");
`endif

endmodule
